@@ rtl/dyuv_pkg.sv @@
// shared constants, types and the chroma level table of the depth to yuv encoder
package dyuv_pkg;

  localparam int DEPTH_W       = 16;
  localparam int CFG_W         = 16;
  localparam int GEOM_CFG_W    = 13;
  localparam int LUMA_ADDR_W   = 24;
  localparam int CHROMA_ADDR_W = 25;
  localparam int BYTE_W        = 8;
  localparam int LEVEL_W       = 3;
  localparam int LEVEL_TOP     = 4;
  localparam int LEVEL_SHIFT   = 2;
  localparam int NUM_W         = DEPTH_W + LEVEL_SHIFT;
  localparam int REM_W         = DEPTH_W + BYTE_W;

  localparam logic [GEOM_CFG_W-1:0] FRAME_WIDTH_RST  = GEOM_CFG_W'(640);
  localparam logic [GEOM_CFG_W-1:0] FRAME_HEIGHT_RST = GEOM_CFG_W'(576);
  localparam logic [DEPTH_W-1:0]    DEPTH_LOW_RST    = '0;
  localparam logic [DEPTH_W-1:0]    DEPTH_HIGH_RST   = '1;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_DEPTH_LOW,
    CFG_DEPTH_HIGH
  } cfg_index_t;

  typedef struct packed {
    logic               last;
    logic               need_div;
    logic [LEVEL_W-1:0] level;
    logic [NUM_W-1:0]   num;
    logic [DEPTH_W-1:0] den;
  } dyuv_pix_t;

  function automatic logic [BYTE_W-1:0] level_byte(input logic [LEVEL_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0:    b = 8'd0;
      3'd1:    b = 8'd64;
      3'd2:    b = 8'd128;
      3'd3:    b = 8'd196;
      3'd4:    b = 8'd255;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/dyuv_ifs.sv @@
// pixel and result stream interfaces of the depth to yuv encoder
interface dyuv_in_if import dyuv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_sample;
  logic               frame_start;

  modport source(output valid, depth_sample, frame_start, input ready);
  modport sink(input valid, depth_sample, frame_start, output ready);
endinterface

interface dyuv_out_if import dyuv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     write_valid;
  logic [LUMA_ADDR_W-1:0]   luma_address;
  logic [BYTE_W-1:0]        luma_value;
  logic [CHROMA_ADDR_W-1:0] u_address;
  logic [CHROMA_ADDR_W-1:0] v_address;
  logic [BYTE_W-1:0]        u_value;
  logic [BYTE_W-1:0]        v_value;
  logic                     frame_end;

  modport source(output valid, write_valid, luma_address, luma_value, u_address,
                 v_address, u_value, v_value, frame_end, input ready);
  modport sink(input valid, write_valid, luma_address, luma_value, u_address,
               v_address, u_value, v_value, frame_end, output ready);
endinterface

@@ rtl/depth16_to_yuv_pixel_encoder.sv @@
// top level of the depth to yuv pixel encoder
//
// in_pix carries one 16-bit depth pixel per transaction, with frame_start marking
// column 0, row 0. out_pix carries one result per pixel: luma and chroma bytes,
// their buffer addresses, a write flag and a frame end flag. Both channels move a
// transaction on a clock edge with valid and ready high.
// cfg_we, cfg_index and cfg_data write frame width, frame height, depth low and
// depth high, one register per cycle. The user must write them only while no
// pixel is in flight; the block itself does not enforce it.
// The front end takes a pixel and places it in a two-entry queue in the same
// cycle; the back end then forms the four address products on one shared
// multiplier and, for a pixel inside the depth range, runs the 10-step
// restoring divider for the level and luma bits, which a pixel on a clamp or
// step skips. The result is then registered for out_pix.
// Synchronous reset loads the default geometry 640 x 576 and depth range 0 to
// 65535, clears the raster counters and empties the queue and result register.
// When out_pix stalls, the result waits in its register, the back end holds,
// and the front end keeps accepting pixels until the queue is full.
module depth16_to_yuv_pixel_encoder import dyuv_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  dyuv_in_if.sink          in_pix,
  dyuv_out_if.source       out_pix,
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int JW = RW + CW + $bits(dyuv_pix_t);

  logic          q_push, q_full, q_pop, q_empty;
  logic [JW-1:0] q_wdata, q_rdata;
  logic [WW-1:0] frame_w;
  logic [HW-1:0] frame_h;

  dyuv_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full),
    .frame_w  (frame_w),
    .frame_h  (frame_h)
  );

  dyuv_queue #(
    .DW(JW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  dyuv_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .frame_w(frame_w),
    .frame_h(frame_h),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .q_data (q_rdata),
    .out_pix(out_pix)
  );

endmodule

@@ rtl/dyuv_front.sv @@
// front end: config registers, raster counters and depth classification
module dyuv_front import dyuv_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int JW = RW + CW + $bits(dyuv_pix_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  dyuv_in_if.sink          in_pix,
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             q_push,
  output logic [JW-1:0]    q_data,
  input  logic             q_full,
  output logic [WW-1:0]    frame_w,
  output logic [HW-1:0]    frame_h
);

  logic [GEOM_CFG_W-1:0] fw_r, fh_r;
  logic [DEPTH_W-1:0]    dlow_r, dhigh_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;

  logic [WW-1:0]      w, c0, c1, cn;
  logic [HW-1:0]      h, r0, r1, r2, rn;
  logic [DEPTH_W-1:0] d, diff;
  dyuv_pix_t          pix;

  // geometry clamp
  always_comb begin
    if (fw_r < GEOM_CFG_W'(2)) begin
      w = WW'(2);
    end else if ({1'b0, fw_r} > (GEOM_CFG_W + 1)'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_r);
    end
    if (fh_r < GEOM_CFG_W'(1)) begin
      h = HW'(1);
    end else if ({1'b0, fh_r} > (GEOM_CFG_W + 1)'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(fh_r);
    end
  end

  assign frame_w = w;
  assign frame_h = h;

  // raster position with folding of stale counters
  always_comb begin
    c0 = in_pix.frame_start ? '0 : WW'(col_r);
    r0 = in_pix.frame_start ? '0 : HW'(row_r);
    c1 = c0;
    r1 = r0;
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end
    r2 = (r1 >= h) ? '0 : r1;
    cn = c1 + 1'b1;
    rn = r2;
    col_nxt = CW'(cn);
    if (cn >= w) begin
      col_nxt = '0;
      rn = r2 + 1'b1;
      if (rn >= h) begin
        rn = '0;
      end
    end
    row_nxt = RW'(rn);
  end

  // depth classification
  always_comb begin
    d = in_pix.depth_sample;
    diff = d - dlow_r;
    pix.last     = (c1 == w - 1'b1) && (r2 == h - 1'b1);
    pix.need_div = 1'b0;
    pix.level    = '0;
    pix.num      = NUM_W'(diff) << LEVEL_SHIFT;
    pix.den      = dhigh_r - dlow_r;
    if (dhigh_r <= dlow_r) begin
      pix.level = (d < dlow_r) ? '0 : LEVEL_W'(LEVEL_TOP);
    end else if (d <= dlow_r) begin
      pix.level = '0;
    end else if (d >= dhigh_r) begin
      pix.level = LEVEL_W'(LEVEL_TOP);
    end else begin
      pix.need_div = 1'b1;
    end
  end

  assign in_pix.ready = !q_full;
  assign q_push       = in_pix.valid && !q_full;
  assign q_data       = {RW'(r2), CW'(c1), pix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= FRAME_WIDTH_RST;
      fh_r    <= FRAME_HEIGHT_RST;
      dlow_r  <= DEPTH_LOW_RST;
      dhigh_r <= DEPTH_HIGH_RST;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r    <= cfg_data[GEOM_CFG_W-1:0];
          CFG_FRAME_HEIGHT: fh_r    <= cfg_data[GEOM_CFG_W-1:0];
          CFG_DEPTH_LOW:    dlow_r  <= cfg_data[DEPTH_W-1:0];
          CFG_DEPTH_HIGH:   dhigh_r <= cfg_data[DEPTH_W-1:0];
        endcase
      end
      if (q_push) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

@@ rtl/dyuv_queue.sv @@
// two-entry queue between front and back end
module dyuv_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [NW-1:0] cnt_r;

  assign full     = (cnt_r == NW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/dyuv_back.sv @@
// back end: address sequencer on a shared multiplier, bit-serial divider, result register
module dyuv_back import dyuv_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int PW = $bits(dyuv_pix_t),
  localparam int JW = RW + CW + PW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [WW-1:0] frame_w,
  input  logic [HW-1:0] frame_h,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic [JW-1:0] q_data,
  dyuv_out_if.source    out_pix
);

  localparam int AW = WW + HW;
  localparam int XW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD1, S_ADD2, S_DIVA, S_SCALE, S_DIVB, S_OUT
  } state_t;

  state_t             state_r;
  logic [2:0]         step_r;
  dyuv_pix_t          pix_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [AW-1:0]      lsize_r, csize_r, rbase_r, cbase_r;
  logic [XW-1:0]      laddr_r, cidx_r, yuv_r, u_r, v_r;
  logic [REM_W-1:0]   rem_r, dsh_r;
  logic [LEVEL_W-1:0] level_r;
  logic [BYTE_W-1:0]  q_r;

  logic                     out_valid_r, wv_r, fe_r;
  logic [LUMA_ADDR_W-1:0]   oladdr_r;
  logic [CHROMA_ADDR_W-1:0] ouaddr_r, ovaddr_r;
  logic [BYTE_W-1:0]        oluma_r, ou_r, ov_r;

  dyuv_pix_t     job_pix;
  logic [CW-1:0] job_col;
  logic [RW-1:0] job_row;
  logic [WW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [AW-1:0] prod;
  logic          ge, wvalid;

  assign job_pix = dyuv_pix_t'(q_data[PW-1:0]);
  assign job_col = q_data[PW+CW-1:PW];
  assign job_row = q_data[JW-1:PW+CW];
  assign q_pop   = (state_r == S_IDLE) && !q_empty;

  // shared multiplier operand select
  always_comb begin
    unique case (step_r[1:0])
      2'd3: begin
        mul_a = frame_w;
        mul_b = frame_h;
      end
      2'd2: begin
        mul_a = frame_w >> 1;
        mul_b = frame_h >> 1;
      end
      2'd1: begin
        mul_a = frame_w;
        mul_b = HW'(row_r);
      end
      default: begin
        mul_a = frame_w;
        mul_b = HW'(row_r >> 2);
      end
    endcase
    prod = AW'(mul_a) * AW'(mul_b);
  end

  assign ge     = (rem_r >= dsh_r);
  assign wvalid = (u_r < yuv_r) && (v_r < yuv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_pix.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_pix.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            pix_r   <= job_pix;
            col_r   <= job_col;
            row_r   <= job_row;
            level_r <= job_pix.level;
            q_r     <= '0;
            rem_r   <= REM_W'(job_pix.num);
            dsh_r   <= REM_W'(job_pix.den) << (LEVEL_SHIFT - 1);
            step_r  <= 3'd3;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (step_r[1:0])
            2'd3:    lsize_r <= prod;
            2'd2:    csize_r <= prod;
            2'd1:    rbase_r <= prod;
            default: cbase_r <= prod;
          endcase
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= S_ADD1;
          end
        end
        S_ADD1: begin
          laddr_r <= XW'(rbase_r) + XW'(col_r);
          cidx_r  <= XW'(col_r >> 1) + XW'(cbase_r)
                   + (row_r[1] ? XW'(frame_w >> 1) : '0);
          yuv_r   <= XW'(lsize_r) + (XW'(csize_r) << 1);
          state_r <= S_ADD2;
        end
        S_ADD2: begin
          u_r     <= XW'(lsize_r) + cidx_r;
          v_r     <= XW'(lsize_r) + XW'(csize_r) + cidx_r;
          step_r  <= 3'(LEVEL_SHIFT - 1);
          state_r <= pix_r.need_div ? S_DIVA : S_OUT;
        end
        S_DIVA: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          level_r <= {level_r[LEVEL_W-2:0], ge};
          dsh_r   <= dsh_r >> 1;
          step_r  <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          rem_r   <= (rem_r << BYTE_W) - rem_r;
          dsh_r   <= REM_W'(pix_r.den) << (BYTE_W - 1);
          step_r  <= 3'(BYTE_W - 1);
          state_r <= S_DIVB;
        end
        S_DIVB: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r    <= {q_r[BYTE_W-2:0], ge};
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_pix.ready) begin
            wv_r        <= wvalid;
            oladdr_r    <= LUMA_ADDR_W'(laddr_r);
            ouaddr_r    <= CHROMA_ADDR_W'(u_r);
            ovaddr_r    <= CHROMA_ADDR_W'(v_r);
            oluma_r     <= wvalid ? q_r : '0;
            ou_r        <= wvalid ? level_byte(level_r) : '0;
            ov_r        <= wvalid ? level_byte(level_r) : '0;
            fe_r        <= pix_r.last;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.write_valid  = wv_r;
  assign out_pix.luma_address = oladdr_r;
  assign out_pix.luma_value   = oluma_r;
  assign out_pix.u_address    = ouaddr_r;
  assign out_pix.v_address    = ovaddr_r;
  assign out_pix.u_value      = ou_r;
  assign out_pix.v_value      = ov_r;
  assign out_pix.frame_end    = fe_r;

endmodule

@@ verif/depth16_to_yuv_pixel_encoder_tb.sv @@
// self-checking testbench of the depth to yuv pixel encoder with its own pixel predictor
`timescale 1ns / 100ps

module depth16_to_yuv_pixel_encoder_tb;
  import dyuv_pkg::*;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RANDOM_ITEMS = 1050;
  localparam int LATENCY      = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               start;
  } raw_pixel_t;

  typedef struct packed {
    logic                     write_valid;
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic [BYTE_W-1:0]        luma_value;
    logic [CHROMA_ADDR_W-1:0] u_address;
    logic [CHROMA_ADDR_W-1:0] v_address;
    logic [BYTE_W-1:0]        u_value;
    logic [BYTE_W-1:0]        v_value;
    logic                     frame_end;
  } yuv_pixel_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dyuv_in_if  in_pix ();
  dyuv_out_if out_pix ();

  depth16_to_yuv_pixel_encoder #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_pix  (out_pix),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  const byte unsigned chroma_levels[LEVEL_TOP+1] = '{0, 64, 128, 196, 255};

  // shadow of the register file and the raster position
  int unsigned width_reg, height_reg, depth_lo_reg, depth_hi_reg;
  int unsigned raster_col, raster_row;

  raw_pixel_t pending_pixels[$];
  yuv_pixel_t expected_pixels[$];

  int unsigned n_queued, n_accepted, n_results, n_skipped, n_frame_ends;
  int unsigned n_settings, errors, cycle_count;
  int unsigned src_idle_pct, sink_stall_pct;
  bit          in_fired;

  function automatic int unsigned frame_w();
    return (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
  endfunction

  function automatic yuv_pixel_t encode_pixel(logic [DEPTH_W-1:0] depth, logic start);
    int unsigned w, h, col, row, half_w, luma_size, chroma_size, yuv_size;
    int unsigned cx, cy, cidx, u_addr, v_addr, lvl, luma, num, den, d;
    bit          ok;
    yuv_pixel_t  r;
    w = frame_w();
    h = frame_h();
    d = depth;
    if (start) begin
      raster_col = 0;
      raster_row = 0;
    end
    if (raster_col >= w) begin
      raster_col = 0;
      raster_row = raster_row + 1;
    end
    if (raster_row >= h) raster_row = 0;
    col = raster_col;
    row = raster_row;

    half_w      = w / 2;
    luma_size   = w * h;
    chroma_size = half_w * (h / 2);
    yuv_size    = luma_size + 2 * chroma_size;
    cx          = col / 2;
    cy          = row / 2;
    cidx        = cx + ((cy & 1) ? half_w : 0) + (cy / 2) * w;
    u_addr      = luma_size + cidx;
    v_addr      = luma_size + chroma_size + cidx;
    ok          = (u_addr < yuv_size) && (v_addr < yuv_size);

    if (depth_hi_reg <= depth_lo_reg) begin
      lvl  = (d < depth_lo_reg) ? 0 : LEVEL_TOP;
      luma = 0;
    end else if (d <= depth_lo_reg) begin
      lvl  = 0;
      luma = 0;
    end else if (d >= depth_hi_reg) begin
      lvl  = LEVEL_TOP;
      luma = 0;
    end else begin
      den  = depth_hi_reg - depth_lo_reg;
      num  = (d - depth_lo_reg) * LEVEL_TOP;
      lvl  = num / den;
      luma = ((num % den) * 255) / den;
      if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
    end

    r.write_valid  = ok;
    r.luma_address = LUMA_ADDR_W'(row * w + col);
    r.luma_value   = ok ? BYTE_W'(luma) : '0;
    r.u_address    = CHROMA_ADDR_W'(u_addr);
    r.v_address    = CHROMA_ADDR_W'(v_addr);
    r.u_value      = ok ? BYTE_W'(chroma_levels[lvl]) : '0;
    r.v_value      = ok ? BYTE_W'(chroma_levels[lvl]) : '0;
    r.frame_end    = (col == w - 1) && (row == h - 1);

    raster_col = col + 1;
    if (raster_col >= w) begin
      raster_col = 0;
      raster_row = row + 1;
      if (raster_row >= h) raster_row = 0;
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_pixel(logic [DEPTH_W-1:0] depth, logic start);
    raw_pixel_t p;
    p.depth = depth;
    p.start = start;
    pending_pixels.push_back(p);
    n_queued++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg    = value & 16'h1FFF;
      CFG_FRAME_HEIGHT: height_reg   = value & 16'h1FFF;
      CFG_DEPTH_LOW:    depth_lo_reg = value;
      CFG_DEPTH_HIGH:   depth_hi_reg = value;
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_pixels.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int r, v;
    r = $urandom_range(99);
    if (r < 35) v = $urandom_range(65535);
    else if (r < 50) v = int'(depth_lo_reg) + int'($urandom_range(2)) - 1;
    else if (r < 65) v = int'(depth_hi_reg) + int'($urandom_range(2)) - 1;
    else v = $urandom_range(depth_hi_reg, depth_lo_reg);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DEPTH_W'(v);
  endfunction

  task automatic random_settings();
    int unsigned      r, lo;
    logic [CFG_W-1:0] wv, hv;
    r = $urandom_range(99);
    if (r < 70) wv = CFG_W'($urandom_range(9, 2));
    else if (r < 78) wv = CFG_W'($urandom_range(40, 10));
    else if (r < 85) wv = CFG_W'($urandom_range(1, 0));
    else if (r < 93) wv = ($urandom_range(1) != 0) ? 16'd4096 : 16'h1FFF;
    else wv = CFG_W'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 72) hv = CFG_W'($urandom_range(6, 1));
    else if (r < 80) hv = CFG_W'($urandom_range(20, 7));
    else if (r < 86) hv = 16'd0;
    else if (r < 94) hv = ($urandom_range(1) != 0) ? 16'd4096 : 16'h1FFF;
    else hv = CFG_W'($urandom_range(65535));
    write_reg(CFG_FRAME_WIDTH, wv);
    write_reg(CFG_FRAME_HEIGHT, hv);
    r = $urandom_range(99);
    if (r < 15) begin
      write_reg(CFG_DEPTH_LOW, 16'd0);
      write_reg(CFG_DEPTH_HIGH, 16'hFFFF);
    end else if (r < 30) begin
      lo = $urandom_range(65535);
      write_reg(CFG_DEPTH_LOW, CFG_W'(lo));
      write_reg(CFG_DEPTH_HIGH, CFG_W'($urandom_range(lo, 0)));
    end else if (r < 40) begin
      lo = $urandom_range(65534);
      write_reg(CFG_DEPTH_LOW, CFG_W'(lo));
      write_reg(CFG_DEPTH_HIGH, CFG_W'(lo + $urandom_range(3, 1)));
    end else begin
      write_reg(CFG_DEPTH_LOW, CFG_W'($urandom_range(65535)));
      write_reg(CFG_DEPTH_HIGH, CFG_W'($urandom_range(65535)));
    end
    end_cfg();
  endtask

  task automatic queue_frames(int unsigned n);
    int unsigned k, pix;
    k   = 0;
    pix = frame_w() * frame_h();
    for (int unsigned i = 0; i < n; i++) begin
      // broken frame: restart early
      if ($urandom_range(99) < 2) k = 0;
      push_pixel(pick_depth(), k == 0);
      k = (k + 1 >= pix) ? 0 : k + 1;
    end
  endtask

  task automatic queue_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pixel(pick_depth(), $urandom_range(99) < 10);
  endtask

  // input side
  always @(posedge clk) begin
    in_fired = rst_n && in_pix.valid && in_pix.ready;
    if (in_fired) begin
      expected_pixels.push_back(encode_pixel(in_pix.depth_sample, in_pix.frame_start));
      n_accepted++;
    end
  end

  always @(negedge clk) begin : pixel_driver
    raw_pixel_t p;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
    end else if (!in_pix.valid || in_fired) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        p = pending_pixels.pop_front();
        in_pix.valid        <= 1'b1;
        in_pix.depth_sample <= p.depth;
        in_pix.frame_start  <= p.start;
      end else begin
        in_pix.valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (!rst_n) out_pix.ready <= 1'b0;
    else out_pix.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    yuv_pixel_t want;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      n_results++;
      if (!out_pix.write_valid) n_skipped++;
      if (out_pix.frame_end) n_frame_ends++;
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: result with nothing expected, luma_address 0x%0h", $time,
                 out_pix.luma_address);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("write_valid", want.write_valid, out_pix.write_valid);
        check_field("luma_address", want.luma_address, out_pix.luma_address);
        check_field("luma_value", want.luma_value, out_pix.luma_value);
        check_field("u_address", want.u_address, out_pix.u_address);
        check_field("v_address", want.v_address, out_pix.v_address);
        check_field("u_value", want.u_value, out_pix.u_value);
        check_field("v_value", want.v_value, out_pix.v_value);
        check_field("frame_end", want.frame_end, out_pix.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_rand, n;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_FRAME_WIDTH;
    cfg_data            = '0;
    in_pix.valid        = 1'b0;
    in_pix.depth_sample = '0;
    in_pix.frame_start  = 1'b0;
    out_pix.ready       = 1'b0;
    width_reg           = 640;
    height_reg          = 576;
    depth_lo_reg        = 0;
    depth_hi_reg        = 65535;
    raster_col          = 0;
    raster_row          = 0;
    src_idle_pct        = 10;
    sink_stall_pct      = 10;
    n_rand              = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry and full depth range
    push_pixel(16'd0, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'd1, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'd16384, 1'b0);
    push_pixel(16'd32768, 1'b0);
    push_pixel(16'd49151, 1'b0);
    wait_idle();

    // odd 3x3 frame: skipped pixels, frame end and wrap
    write_reg(CFG_FRAME_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    write_reg(CFG_DEPTH_LOW, 16'd1000);
    write_reg(CFG_DEPTH_HIGH, 16'd2000);
    end_cfg();
    push_pixel(16'd999, 1'b1);
    push_pixel(16'd1000, 1'b0);
    push_pixel(16'd1001, 1'b0);
    push_pixel(16'd1250, 1'b0);
    push_pixel(16'd1999, 1'b0);
    push_pixel(16'd2000, 1'b0);
    push_pixel(16'd2001, 1'b0);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'd0, 1'b0);
    push_pixel(16'd1500, 1'b0);
    push_pixel(16'd1750, 1'b0);
    wait_idle();

    // stale counters after shrinking the frame, then equal and inverted depth range
    write_reg(CFG_FRAME_WIDTH, 16'd2);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    write_reg(CFG_DEPTH_LOW, 16'd5000);
    write_reg(CFG_DEPTH_HIGH, 16'd5000);
    end_cfg();
    push_pixel(16'd4999, 1'b0);
    push_pixel(16'd5000, 1'b0);
    push_pixel(16'd5001, 1'b0);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
    write_reg(CFG_FRAME_HEIGHT, 16'h1FFF);
    write_reg(CFG_DEPTH_HIGH, 16'd4000);
    end_cfg();
    push_pixel(16'd4999, 1'b1);
    push_pixel(16'd5000, 1'b0);

    while (n_rand < RANDOM_ITEMS) begin
      wait_idle();
      random_settings();
      src_idle_pct   = (n_rand >= 400 && n_rand < 650) ? 0 : 10;
      sink_stall_pct = src_idle_pct;
      n = (frame_w() * frame_h() > 4096) ? $urandom_range(12, 4) : $urandom_range(110, 40);
      if ($urandom_range(99) < 80) queue_frames(n);
      else queue_noise(n);
      n_rand += n;
    end

    wait_idle();
    repeat (LATENCY + 5) @(posedge clk);
    if (expected_pixels.size() != 0) errors++;
    $display("%0d pixels over %0d register settings, %0d results checked", n_accepted,
             n_settings, n_results);
    $display("%0d skipped pixels, %0d frame ends, %0d mismatches", n_skipped, n_frame_ends,
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
